FILE: src/payload_power_session_controller_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the payload power session controller
// Use clock and reset from the scope where the macro is expanded.
// ---------------------------------------------------------------------------
`ifndef PAYLOAD_POWER_SESSION_CONTROLLER_TOP_ASSERT_SVH
`define PAYLOAD_POWER_SESSION_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent
`define PPSC_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("ppsc assertion failed");
// Check that the consequent holds in the cycle after the antecedent
`define PPSC_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("ppsc assertion failed");
`else
`define PPSC_ASSERT_NOW(label, cond, expr)
`define PPSC_ASSERT_NEXT(label, cond, expr)
`endif

`endif

FILE: src/ppsc_pkg.sv
// ---------------------------------------------------------------------------
// ppsc_pkg
// Types, constants and beacon encoding for the payload power controller.
// ---------------------------------------------------------------------------
package ppsc_pkg;

   // Counter and field widths
   localparam int CNT_W     = 24;
   localparam int OP_W      = 2;
   localparam int CODE_W    = 5;
   localparam int IDX_W     = 2;
   localparam int CFG_W     = 24;
   localparam int STEP_W    = 22;
   localparam int BUCKETS   = 5;
   localparam int MUL_W     = STEP_W + 3;
   localparam int BKT_W     = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Register reset values
   localparam logic [CFG_W-1:0]  STARTUP_RST  = CFG_W'(90000);
   localparam logic [CFG_W-1:0]  SHUTDOWN_RST = CFG_W'(15000);
   localparam logic [CFG_W-1:0]  MAX_SES_RST  = CFG_W'(600000);
   localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(120000);

   // Register indexes
   localparam logic [IDX_W-1:0] REG_STARTUP  = 2'd0;
   localparam logic [IDX_W-1:0] REG_SHUTDOWN = 2'd1;
   localparam logic [IDX_W-1:0] REG_MAX_SES  = 2'd2;
   localparam logic [IDX_W-1:0] REG_STEP     = 2'd3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_PHOTO = 2'd1;
   localparam logic [OP_W-1:0] OP_COMMS = 2'd2;

   // Beacon codes
   localparam logic [CODE_W-1:0] CODE_NONE       = 5'd0;
   localparam logic [CODE_W-1:0] CODE_COMMS_TO   = 5'd1;
   localparam logic [CODE_W-1:0] CODE_COMMS_BASE = 5'd2;
   localparam logic [CODE_W-1:0] CODE_PHOTO_TO   = 5'd7;
   localparam logic [CODE_W-1:0] CODE_PHOTO_BASE = 5'd8;
   localparam logic [CODE_W-1:0] CODE_OC_BASE    = 5'd13;
   localparam logic [CODE_W-1:0] CODE_UNKNOWN    = 5'd18;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_COMMS,
      ACT_PHOTO,
      ACT_OVERCURRENT
   } act_type;

   typedef logic [BUCKETS-1:0][MUL_W-1:0] mult_vec_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic            shutdown_vote_a;
      logic            shutdown_vote_b;
      logic            shutdown_vote_c;
      logic            overcurrent_sense;
   } req_item_type;

   typedef struct packed {
      logic              payload_power;
      logic              mode_is_comms;
      logic              call_ok;
      logic [CODE_W-1:0] beacon_code;
      logic              timeout_flag;
      logic              overcurrent_flag;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] arm_delay;
      logic [CFG_W-1:0] off_delay;
      logic [CFG_W-1:0] max_session;
      mult_vec_type     bucket_limit;
   } cfg_type;

   // Upper bound of each bucket: step times one through five
   function automatic mult_vec_type step_multiples(logic [STEP_W-1:0] step);
      mult_vec_type m;
      for (int k = 0; k < BUCKETS; k++) begin
         m[k] = MUL_W'(step) * MUL_W'(k + 1);
      end
      return m;
   endfunction

   // Build the beacon code from activity, timeout and duration bucket
   function automatic logic [CODE_W-1:0] beacon_of(act_type act, logic timed_out,
                                                    logic [CNT_W-1:0] dur,
                                                    mult_vec_type lim);
      logic [BKT_W-1:0]  bkt;
      logic [CODE_W-1:0] code;
      bkt = BKT_W'(BUCKETS);
      for (int k = BUCKETS - 1; k >= 0; k--) begin
         if (MUL_W'(dur) <= lim[k]) begin
            bkt = BKT_W'(k);
         end
      end
      case (act)
         ACT_COMMS: begin
            if (timed_out) begin
               code = CODE_COMMS_TO;
            end else if (bkt < BKT_W'(BUCKETS)) begin
               code = CODE_COMMS_BASE + CODE_W'(bkt);
            end else begin
               code = CODE_UNKNOWN;
            end
         end
         ACT_PHOTO: begin
            if (timed_out) begin
               code = CODE_PHOTO_TO;
            end else if (bkt < BKT_W'(BUCKETS)) begin
               code = CODE_PHOTO_BASE + CODE_W'(bkt);
            end else begin
               code = CODE_UNKNOWN;
            end
         end
         ACT_OVERCURRENT: begin
            if (bkt < BKT_W'(BUCKETS)) begin
               code = CODE_OC_BASE + CODE_W'(bkt);
            end else begin
               code = CODE_UNKNOWN;
            end
         end
         default: begin
            code = CODE_NONE;
         end
      endcase
      return code;
   endfunction

endpackage

FILE: src/ppsc_if.sv
// ---------------------------------------------------------------------------
// ppsc channel interfaces
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface ppsc_req_if;
   logic                     valid;
   logic                     ready;
   logic [ppsc_pkg::OP_W-1:0] operation;
   logic                     shutdown_vote_a;
   logic                     shutdown_vote_b;
   logic                     shutdown_vote_c;
   logic                     overcurrent_sense;

   modport source (
      output valid, operation, shutdown_vote_a, shutdown_vote_b, shutdown_vote_c,
             overcurrent_sense,
      input  ready
   );
   modport sink (
      input  valid, operation, shutdown_vote_a, shutdown_vote_b, shutdown_vote_c,
             overcurrent_sense,
      output ready
   );
endinterface

interface ppsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        payload_power;
   logic                        mode_is_comms;
   logic                        call_ok;
   logic [ppsc_pkg::CODE_W-1:0] beacon_code;
   logic                        timeout_flag;
   logic                        overcurrent_flag;

   modport source (
      output valid, payload_power, mode_is_comms, call_ok, beacon_code, timeout_flag,
             overcurrent_flag,
      input  ready
   );
   modport sink (
      input  valid, payload_power, mode_is_comms, call_ok, beacon_code, timeout_flag,
             overcurrent_flag,
      output ready
   );
endinterface

interface ppsc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [ppsc_pkg::IDX_W-1:0] index;
   logic [ppsc_pkg::CFG_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: src/ppsc_csr.sv
// ---------------------------------------------------------------------------
// ppsc_csr
// Configuration registers; bucket bounds are precomputed on each step write.
// ---------------------------------------------------------------------------
module ppsc_csr (
   input  logic              clock,
   input  logic              reset,
   ppsc_csr_if.sink          csr_bus,
   output ppsc_pkg::cfg_type cfg
);
   import ppsc_pkg::*;

   logic [CFG_W-1:0] startup_ff, startup_in;
   logic [CFG_W-1:0] shutdown_ff, shutdown_in;
   logic [CFG_W-1:0] max_ses_ff, max_ses_in;
   mult_vec_type     limit_ff, limit_in;
   logic             wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en = csr_bus.valid;

   // Decode the register write
   always_comb begin
      startup_in  = startup_ff;
      shutdown_in = shutdown_ff;
      max_ses_in  = max_ses_ff;
      limit_in    = limit_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            REG_STARTUP:  startup_in  = csr_bus.wdata;
            REG_SHUTDOWN: shutdown_in = csr_bus.wdata;
            REG_MAX_SES:  max_ses_in  = csr_bus.wdata;
            REG_STEP:     limit_in    = step_multiples(csr_bus.wdata[STEP_W-1:0]);
            default:      startup_in  = startup_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_ff  <= STARTUP_RST;
         shutdown_ff <= SHUTDOWN_RST;
         max_ses_ff  <= MAX_SES_RST;
         limit_ff    <= step_multiples(STEP_RST);
      end else begin
         startup_ff  <= startup_in;
         shutdown_ff <= shutdown_in;
         max_ses_ff  <= max_ses_in;
         limit_ff    <= limit_in;
      end
   end

   assign cfg.arm_delay      = startup_ff;
   assign cfg.off_delay      = shutdown_ff;
   assign cfg.max_session    = max_ses_ff;
   assign cfg.bucket_limit   = limit_ff;

endmodule

FILE: src/ppsc_core.sv
// ---------------------------------------------------------------------------
// ppsc_core
// Session state and the per-item update: start, tick checks, beacon code.
// ---------------------------------------------------------------------------
module ppsc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ppsc_pkg::req_item_type item,
   input  ppsc_pkg::cfg_type      cfg,
   output ppsc_pkg::rsp_item_type result
);
   import ppsc_pkg::*;

   logic             active_ff, active_in;
   logic [CNT_W-1:0] ses_ela_ff, ses_ela_in;
   logic             wait_ff, wait_in;
   logic [CNT_W-1:0] sd_ela_ff, sd_ela_in;
   logic             comms_ff, comms_in;
   act_type          act_ff, act_in;
   logic [CNT_W-1:0] dur_ff, dur_in;
   logic             to_ff, to_in;
   logic             oc_ff, oc_in;
   logic             ok;
   logic             vote;

   // Two of three shutdown lines
   assign vote = (item.shutdown_vote_a & item.shutdown_vote_b) |
                 (item.shutdown_vote_a & item.shutdown_vote_c) |
                 (item.shutdown_vote_b & item.shutdown_vote_c);

   // Next session state for the item in the input register
   always_comb begin
      active_in  = active_ff;
      ses_ela_in = ses_ela_ff;
      wait_in    = wait_ff;
      sd_ela_in  = sd_ela_ff;
      comms_in   = comms_ff;
      act_in     = act_ff;
      dur_in     = dur_ff;
      to_in      = to_ff;
      oc_in      = oc_ff;
      ok         = 1'b0;
      case (item.operation) inside
         OP_TICK: begin
            ok = 1'b1;
            // advance timers, saturating
            if (active_ff && ses_ela_ff != CNT_MAX) begin
               ses_ela_in = ses_ela_ff + 1'b1;
            end
            if (wait_ff && sd_ela_ff != CNT_MAX) begin
               sd_ela_in = sd_ela_ff + 1'b1;
            end
            // shutdown vote
            if (active_ff && ses_ela_in > cfg.arm_delay && vote) begin
               if (wait_ff) begin
                  if (sd_ela_in > cfg.off_delay) begin
                     active_in = 1'b0;
                     wait_in   = 1'b0;
                     dur_in    = ses_ela_in;
                  end
               end else begin
                  wait_in   = 1'b1;
                  sd_ela_in = '0;
               end
            end
            // session time limit, then overcurrent
            if (active_in && ses_ela_in > cfg.max_session) begin
               active_in = 1'b0;
               wait_in   = 1'b0;
               dur_in    = ses_ela_in;
               to_in     = 1'b1;
               ok        = 1'b0;
            end else if (active_in && item.overcurrent_sense) begin
               active_in = 1'b0;
               wait_in   = 1'b0;
               dur_in    = ses_ela_in;
               act_in    = ACT_OVERCURRENT;
               oc_in     = 1'b1;
               ok        = 1'b0;
            end
         end
         OP_PHOTO, OP_COMMS: begin
            if (!active_ff) begin
               ok         = 1'b1;
               comms_in   = (item.operation == OP_COMMS);
               act_in     = (item.operation == OP_COMMS) ? ACT_COMMS : ACT_PHOTO;
               to_in      = 1'b0;
               oc_in      = 1'b0;
               active_in  = 1'b1;
               ses_ela_in = '0;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         ses_ela_ff <= '0;
         wait_ff    <= 1'b0;
         sd_ela_ff  <= '0;
         comms_ff   <= 1'b0;
         act_ff     <= ACT_NONE;
         dur_ff     <= '0;
         to_ff      <= 1'b0;
         oc_ff      <= 1'b0;
      end else if (advance) begin
         active_ff  <= active_in;
         ses_ela_ff <= ses_ela_in;
         wait_ff    <= wait_in;
         sd_ela_ff  <= sd_ela_in;
         comms_ff   <= comms_in;
         act_ff     <= act_in;
         dur_ff     <= dur_in;
         to_ff      <= to_in;
         oc_ff      <= oc_in;
      end
   end

   // Result fields, taken after the item is applied
   assign result.payload_power    = active_in;
   assign result.mode_is_comms    = comms_in;
   assign result.call_ok          = ok;
   assign result.beacon_code      = beacon_of(act_in, to_in, dur_in, cfg.bucket_limit);
   assign result.timeout_flag     = to_in;
   assign result.overcurrent_flag = oc_in;

endmodule

FILE: src/payload_power_session_controller_top.sv
// ---------------------------------------------------------------------------
// payload_power_session_controller_top
// Payload power session controller: input register, session core, result
// register, configuration registers.
// ---------------------------------------------------------------------------
// Flow: an accepted item waits in the input register, its session state update
// is computed combinationally, and it moves into the result register when free.
// Throughput: one item per cycle while rsp_bus.ready stays high; a stalled
// result register holds the item in the input register and blocks new items.
// Reset (synchronous, active high) clears the session state and both
// channel stages and returns the configuration registers to their defaults.
// ---------------------------------------------------------------------------
`include "payload_power_session_controller_top_assert.svh"

module payload_power_session_controller_top (
   input logic         clock,
   input logic         reset,
   ppsc_req_if.sink    req_bus,
   ppsc_rsp_if.source  rsp_bus,
   ppsc_csr_if.sink    csr_bus
);
   import ppsc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type core_result;
   cfg_type      cfg;
   logic         advance;
   logic         req_take;

   // Move the held item to the result register when that register is free
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   ppsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ppsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in                  = 1'b1;
         in_item_in.operation         = req_bus.operation;
         in_item_in.shutdown_vote_a   = req_bus.shutdown_vote_a;
         in_item_in.shutdown_vote_b   = req_bus.shutdown_vote_b;
         in_item_in.shutdown_vote_c   = req_bus.shutdown_vote_c;
         in_item_in.overcurrent_sense = req_bus.overcurrent_sense;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.payload_power    = out_item_ff.payload_power;
   assign rsp_bus.mode_is_comms    = out_item_ff.mode_is_comms;
   assign rsp_bus.call_ok          = out_item_ff.call_ok;
   assign rsp_bus.beacon_code      = out_item_ff.beacon_code;
   assign rsp_bus.timeout_flag     = out_item_ff.timeout_flag;
   assign rsp_bus.overcurrent_flag = out_item_ff.overcurrent_flag;

   // Powered payload never reports a finished-session fault
   `PPSC_ASSERT_NOW(a_power_no_fault, out_valid_ff && out_item_ff.payload_power,
      !out_item_ff.timeout_flag && !out_item_ff.overcurrent_flag)
   // Beacon code stays within the defined codes
   `PPSC_ASSERT_NOW(a_code_range, out_valid_ff, out_item_ff.beacon_code <= CODE_UNKNOWN)
   // Both stages full and stalled: no new item is taken
   `PPSC_ASSERT_NOW(a_full_stall, in_valid_ff && out_valid_ff && !rsp_bus.ready,
      !req_bus.ready)
   // An item moved on always shows up as a result next cycle
   `PPSC_ASSERT_NEXT(a_advance_result, advance, out_valid_ff)

endmodule

FILE: verif/payload_power_session_controller_top_tb.sv
// ---------------------------------------------------------------------------
// payload_power_session_controller_top_tb
// Self-checking bench for the payload power session controller. Drives tick
// and session start items with random gaps, stalls the result side at random,
// and compares every result against an in-bench prediction of the session
// state machine, over several register settings including the extremes.
// ---------------------------------------------------------------------------
module payload_power_session_controller_top_tb;
   import ppsc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int               RSP_LATENCY = 2;
   localparam int               RAND_ITEMS  = 1550;
   localparam int               RAND_PHASES = 8;
   localparam int               CYCLE_LIMIT = 800000;
   localparam logic [CFG_W-1:0]  STEP_TOP    = CFG_W'(3355443);

   logic clock;
   logic reset;
   logic rsp_take = 1'b0;

   ppsc_req_if req_bus ();
   ppsc_rsp_if rsp_bus ();
   ppsc_csr_if csr_bus ();

   assign rsp_bus.ready = rsp_take;

   payload_power_session_controller_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predicted register contents
   logic [CFG_W-1:0]  cfg_startup;
   logic [CFG_W-1:0]  cfg_shutdown;
   logic [CFG_W-1:0]  cfg_max_ses;
   logic [STEP_W-1:0] cfg_step;

   // Predicted session state
   logic             sess_on;
   logic [CNT_W-1:0] sess_ms;
   logic             sd_wait;
   logic [CNT_W-1:0] sd_ms;
   logic             comms_sel;
   act_type          last_act;
   logic [CNT_W-1:0] last_dur;
   logic             to_flag;
   logic             oc_flag;

   rsp_item_type status_q[$];
   int           errors       = 0;
   int           items_sent   = 0;
   int           rsp_checked  = 0;
   int           cfg_settings = 0;
   int           cycle_count  = 0;
   int           rx_hold      = 0;
   bit           rx_free      = 0;
   bit           tx_free      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  status_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 60) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic void cut_supply();
      sess_on  = 1'b0;
      sd_wait  = 1'b0;
      last_dur = sess_ms;
   endfunction

   // Beacon from last activity and duration bucket of width cfg_step
   function automatic logic [CODE_W-1:0] beacon_now();
      int                bkt;
      logic [CODE_W-1:0] code;
      bkt = BUCKETS;
      for (int k = BUCKETS - 1; k >= 0; k--) begin
         if (64'(last_dur) <= 64'(cfg_step) * 64'(k + 1)) begin
            bkt = k;
         end
      end
      case (last_act)
         ACT_COMMS: begin
            if (to_flag) code = CODE_COMMS_TO;
            else if (bkt < BUCKETS) code = CODE_COMMS_BASE + CODE_W'(bkt);
            else code = CODE_UNKNOWN;
         end
         ACT_PHOTO: begin
            if (to_flag) code = CODE_PHOTO_TO;
            else if (bkt < BUCKETS) code = CODE_PHOTO_BASE + CODE_W'(bkt);
            else code = CODE_UNKNOWN;
         end
         ACT_OVERCURRENT: begin
            if (bkt < BUCKETS) code = CODE_OC_BASE + CODE_W'(bkt);
            else code = CODE_UNKNOWN;
         end
         default: begin
            code = CODE_NONE;
         end
      endcase
      return code;
   endfunction

   // Apply one item to the predicted state and return the status it yields
   function automatic rsp_item_type apply_session_item(input req_item_type it);
      rsp_item_type r;
      logic         ok;
      int           votes;
      votes = int'(it.shutdown_vote_a) + int'(it.shutdown_vote_b) + int'(it.shutdown_vote_c);
      ok = 1'b0;
      case (it.operation) inside
         OP_TICK: begin
            ok = 1'b1;
            if (sess_on) sess_ms = sat_bump(sess_ms);
            if (sd_wait) sd_ms = sat_bump(sd_ms);
            // shutdown vote, honored only after the startup delay
            if (sess_on && sess_ms > cfg_startup && votes >= 2) begin
               if (sd_wait) begin
                  if (sd_ms > cfg_shutdown) cut_supply();
               end else begin
                  sd_wait = 1'b1;
                  sd_ms   = '0;
               end
            end
            // session limit wins over overcurrent on the same tick
            if (sess_on && sess_ms > cfg_max_ses) begin
               cut_supply();
               to_flag = 1'b1;
               ok      = 1'b0;
            end else if (sess_on && it.overcurrent_sense) begin
               cut_supply();
               last_act = ACT_OVERCURRENT;
               oc_flag  = 1'b1;
               ok       = 1'b0;
            end
         end
         OP_PHOTO, OP_COMMS: begin
            if (!sess_on) begin
               comms_sel = (it.operation == OP_COMMS);
               last_act  = comms_sel ? ACT_COMMS : ACT_PHOTO;
               to_flag   = 1'b0;
               oc_flag   = 1'b0;
               sess_on   = 1'b1;
               sess_ms   = '0;
               ok        = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      r.payload_power    = sess_on;
      r.mode_is_comms    = comms_sel;
      r.call_ok          = ok;
      r.beacon_code      = beacon_now();
      r.timeout_flag     = to_flag;
      r.overcurrent_flag = oc_flag;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stalls and checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_take) begin
         if (status_q.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = status_q.pop_front();
            rsp_checked++;
            if (rsp_bus.payload_power !== want.payload_power)
               report_mismatch($sformatf("payload_power exp %0b got %0b",
                                         want.payload_power, rsp_bus.payload_power));
            if (rsp_bus.mode_is_comms !== want.mode_is_comms)
               report_mismatch($sformatf("mode_is_comms exp %0b got %0b",
                                         want.mode_is_comms, rsp_bus.mode_is_comms));
            if (rsp_bus.call_ok !== want.call_ok)
               report_mismatch($sformatf("call_ok exp %0b got %0b",
                                         want.call_ok, rsp_bus.call_ok));
            if (rsp_bus.beacon_code !== want.beacon_code)
               report_mismatch($sformatf("beacon_code exp %0d got %0d",
                                         want.beacon_code, rsp_bus.beacon_code));
            if (rsp_bus.timeout_flag !== want.timeout_flag)
               report_mismatch($sformatf("timeout_flag exp %0b got %0b",
                                         want.timeout_flag, rsp_bus.timeout_flag));
            if (rsp_bus.overcurrent_flag !== want.overcurrent_flag)
               report_mismatch($sformatf("overcurrent_flag exp %0b got %0b",
                                         want.overcurrent_flag, rsp_bus.overcurrent_flag));
         end
      end
      // stall mostly short, sometimes long, with stall-free stretches
      if (rx_hold > 0) begin
         rx_hold  = rx_hold - 1;
         rsp_take <= 1'b0;
      end else if (rx_free || $urandom_range(0, 99) < 70) begin
         rsp_take <= 1'b1;
      end else begin
         rsp_take <= 1'b0;
         rx_hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      end
      if ($urandom_range(0, 199) == 0) rx_free = !rx_free;
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   function automatic req_item_type make_req(input logic [OP_W-1:0] op, input int va,
                                             input int vb, input int vc,
                                             input int oc);
      req_item_type it;
      it.operation         = op;
      it.shutdown_vote_a   = va[0];
      it.shutdown_vote_b   = vb[0];
      it.shutdown_vote_c   = vc[0];
      it.overcurrent_sense = oc[0];
      return it;
   endfunction

   // Send one item, predict on acceptance, then idle for a random gap
   task automatic send_item(input req_item_type it);
      int gap;
      int r;
      req_bus.valid             <= 1'b1;
      req_bus.operation         <= it.operation;
      req_bus.shutdown_vote_a   <= it.shutdown_vote_a;
      req_bus.shutdown_vote_b   <= it.shutdown_vote_b;
      req_bus.shutdown_vote_c   <= it.shutdown_vote_c;
      req_bus.overcurrent_sense <= it.overcurrent_sense;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      status_q.push_back(apply_session_item(it));
      items_sent++;
      r = $urandom_range(0, 99);
      if (tx_free || r < 55) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 25);
      if ($urandom_range(0, 63) == 0) tx_free = !tx_free;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off new items until every outstanding result has been checked
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         REG_STARTUP:  cfg_startup  = data;
         REG_SHUTDOWN: cfg_shutdown = data;
         REG_MAX_SES:  cfg_max_ses  = data;
         default:      cfg_step     = data[STEP_W-1:0];
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CFG_W-1:0] startup, input logic [CFG_W-1:0] shutdown,
                             input logic [CFG_W-1:0] max_ses, input logic [CFG_W-1:0] step);
      wait_drained();
      write_reg(REG_STARTUP, startup);
      write_reg(REG_SHUTDOWN, shutdown);
      write_reg(REG_MAX_SES, max_ses);
      write_reg(REG_STEP, step);
      cfg_settings++;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset defaults: idle tick, unused op, refused start, overcurrent
   task automatic test_reset_defaults();
      send_item(make_req(OP_TICK, 1, 1, 1, 1));
      send_item(make_req(OP_UNUSED, 0, 0, 0, 0));
      send_item(make_req(OP_PHOTO, 0, 0, 0, 0));
      send_item(make_req(OP_COMMS, 1, 0, 1, 0));
      send_item(make_req(OP_TICK, 1, 1, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 1));
      send_item(make_req(OP_COMMS, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 1, 0, 1));
   endtask

   // Vote after startup delay, lost vote during wait, power off after wait
   task automatic test_shutdown_vote();
      set_config(CFG_W'(1), CFG_W'(1), CFG_W'(8), CFG_W'(2));
      send_item(make_req(OP_PHOTO, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 1, 0, 0, 0));
      send_item(make_req(OP_TICK, 1, 1, 0, 0));
      send_item(make_req(OP_TICK, 0, 1, 1, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 1, 0, 1, 0));
      send_item(make_req(OP_TICK, 1, 1, 1, 0));
   endtask

   // Session limit, including a limit that lands with overcurrent
   task automatic test_session_limit();
      set_config(CNT_MAX, CNT_MAX, CFG_W'(2), STEP_TOP);
      send_item(make_req(OP_COMMS, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 1, 1, 1, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 1));
      send_item(make_req(OP_PHOTO, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 0));
      set_config('0, '0, '0, CFG_W'(1));
      send_item(make_req(OP_PHOTO, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 1));
   endtask

   // Zero bucket step, then shortest shutdown with unit buckets
   task automatic test_bucket_edges();
      set_config(CFG_W'(3), CFG_W'(2), CFG_W'(50), '0);
      send_item(make_req(OP_PHOTO, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0, 1));
      set_config('0, '0, CNT_MAX, CFG_W'(1));
      send_item(make_req(OP_COMMS, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 1, 1, 0, 0));
      send_item(make_req(OP_TICK, 1, 1, 0, 0));
   endtask

   function automatic logic [CFG_W-1:0] pick_limit(input int small_top);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CNT_MAX;
         2:       return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(0, small_top));
      endcase
   endfunction

   // Random sessions over several register settings
   task automatic test_random_sessions();
      req_item_type     it;
      logic [CFG_W-1:0] step;
      int               vote_pct;
      int               oc_pct;
      int               per_phase;
      vote_pct  = 30;
      oc_pct    = 2;
      per_phase = RAND_ITEMS / RAND_PHASES;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 9))
            0:       step = CFG_W'(1);
            1:       step = STEP_TOP;
            2:       step = CFG_W'($urandom_range(1, 3355443));
            default: step = CFG_W'($urandom_range(1, 6));
         endcase
         set_config(pick_limit(8), pick_limit(6), pick_limit(40), step);
         for (int n = 0; n < per_phase; n++) begin
            // pause the sender once per phase until all results are in
            if (n == per_phase / 2) wait_drained();
            if ($urandom_range(0, 99) < 10) begin
               // noise: any field combination, the unused op included
               it = make_req(OP_W'($urandom_range(0, 3)), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1));
            end else if (!sess_on) begin
               vote_pct = $urandom_range(0, 70);
               oc_pct   = $urandom_range(0, 4);
               it = make_req(($urandom_range(0, 9) < 2) ? OP_TICK :
                             ($urandom_range(0, 1) ? OP_COMMS : OP_PHOTO),
                             $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1));
            end else if ($urandom_range(0, 99) < 6) begin
               it = make_req($urandom_range(0, 1) ? OP_COMMS : OP_PHOTO, $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
               it = make_req(OP_TICK, int'($urandom_range(0, 99) < vote_pct),
                             int'($urandom_range(0, 99) < vote_pct),
                             int'($urandom_range(0, 99) < vote_pct),
                             int'($urandom_range(0, 99) < oc_pct));
            end
            send_item(it);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                     <= 1'b1;
      req_bus.valid             <= 1'b0;
      req_bus.operation         <= OP_TICK;
      req_bus.shutdown_vote_a   <= 1'b0;
      req_bus.shutdown_vote_b   <= 1'b0;
      req_bus.shutdown_vote_c   <= 1'b0;
      req_bus.overcurrent_sense <= 1'b0;
      csr_bus.valid             <= 1'b0;
      csr_bus.index             <= REG_STARTUP;
      csr_bus.wdata             <= '0;
      cfg_startup  = STARTUP_RST;
      cfg_shutdown = SHUTDOWN_RST;
      cfg_max_ses  = MAX_SES_RST;
      cfg_step     = STEP_RST;
      sess_on      = 1'b0;
      sess_ms      = '0;
      sd_wait      = 1'b0;
      sd_ms        = '0;
      comms_sel    = 1'b0;
      last_act     = ACT_NONE;
      last_dur     = '0;
      to_flag      = 1'b0;
      oc_flag      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_shutdown_vote();
      test_session_limit();
      test_bucket_edges();
      test_random_sessions();

      wait_drained();
      if (status_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", status_q.size()));
      end
      $display("run covered %0d items and %0d checked results over %0d register settings",
               items_sent, rsp_checked, cfg_settings);
      $display("mix: votes, shutdown waits, timeouts, overcurrent, refused and unused ops");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
